### rtl/core/enc8b10b_pkg.sv
// Package for the 8b10b symbol encoder: beat types, code tables and
// disparity helpers. No dependencies.
`default_nettype none

package enc8b10b_pkg;

	localparam int unsigned NUM_K = 6;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_CTRL = 1'b1;

	localparam logic [9:0] ERR_SYMBOL = 10'h3FF;
	localparam logic [3:0] A7_NEG     = 4'hE;
	localparam logic [3:0] A7_POS     = 4'h1;
	localparam logic [2:0] Y_P7       = 3'd7;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [9:0] symbol;
		logic       unknown_control;
	} symbol_beat_t;

	// abcdei, a in bit 0
	localparam logic [5:0] SIX_NEG [32] = '{
		6'h39, 6'h2E, 6'h2D, 6'h23, 6'h2B, 6'h25, 6'h26, 6'h07,
		6'h27, 6'h29, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h3A,
		6'h36, 6'h31, 6'h32, 6'h13, 6'h34, 6'h15, 6'h16, 6'h17,
		6'h33, 6'h19, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h35
	};
	localparam logic [5:0] SIX_POS [32] = '{
		6'h06, 6'h11, 6'h12, 6'h23, 6'h14, 6'h25, 6'h26, 6'h38,
		6'h18, 6'h29, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h05,
		6'h09, 6'h31, 6'h32, 6'h13, 6'h34, 6'h15, 6'h16, 6'h28,
		6'h0C, 6'h19, 6'h1A, 6'h24, 6'h1C, 6'h22, 6'h21, 6'h0A
	};

	// fghj, f in bit 0
	localparam logic [3:0] FOUR_NEG [8] = '{
		4'hD, 4'h9, 4'hA, 4'h3, 4'hB, 4'h5, 4'h6, 4'h7
	};
	localparam logic [3:0] FOUR_POS [8] = '{
		4'h2, 4'h9, 4'hA, 4'hC, 4'h4, 4'h5, 4'h6, 4'h8
	};

	// K28.5, K28.1, K28.3, K27.7, K29.7, K23.7
	localparam logic [7:0] K_BYTE [NUM_K] = '{
		8'hBC, 8'h3C, 8'h7C, 8'hFB, 8'hFD, 8'hF7
	};
	localparam logic [9:0] K_NEG [NUM_K] = '{
		10'h17C, 10'h27C, 10'h33C, 10'h05B, 10'h05D, 10'h057
	};
	localparam logic [9:0] K_POS [NUM_K] = '{
		10'h283, 10'h183, 10'h0C3, 10'h3A4, 10'h3A2, 10'h3A8
	};

	function automatic logic [3:0] ones10(input logic [9:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 10; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

	// disparity after a block whose balance point is half
	function automatic logic rd_follow(input logic rd, input logic [3:0] ones,
			input logic [3:0] half);
		logic r;
		if (ones > half) begin
			r = 1'b1;
		end else if (ones < half) begin
			r = 1'b0;
		end else begin
			r = rd;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/enc8b10b_stream_if.sv
// Valid/ready stream interface carrying one beat of type payload_t.
// Depends on nothing; payload types come from enc8b10b_pkg.
`default_nettype none

interface enc8b10b_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/encode_8b10b_symbol_top.sv
// 8b10b symbol encoder: one byte beat in, one 10-bit symbol beat out.
// Depends on enc8b10b_pkg and enc8b10b_stream_if.
//
// Usage:
//   bytes   : sink channel, payload byte_beat_t {cmd, data_byte}; cmd = 1
//             encodes a K character (K28.5/.1/.3, K27.7, K29.7, K23.7).
//   symbols : source channel, payload symbol_beat_t {symbol, unknown_control};
//             symbol holds fghj in 9:6 and abcdei in 5:0, bit 0 sent first.
//   An unsupported K byte yields 3FF with unknown_control set and leaves the
//   running disparity as it was.
// Timing:
//   A beat accepted from bytes lands in the input register, is encoded
//   into the result register and is offered from there on; one beat per
//   cycle sustained while symbols.ready is high. The running disparity
//   is a single bit updated as a beat moves into the result register.
// Reset: arst_n clears both valid flags and sets negative disparity.
// Stall: while symbols.ready is low the result holds; one more beat is still
//   taken into the input register, then bytes.ready drops until the result
//   is taken.
`default_nettype none

module encode_8b10b_symbol_top
	import enc8b10b_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	enc8b10b_stream_if.sink      bytes,
	enc8b10b_stream_if.source    symbols
);

	logic         valid_s1;
	byte_beat_t   beat_s1;
	logic         valid_s2;
	symbol_beat_t beat_s2;
	logic         rd_q;

	logic         adv;
	logic [4:0]   x;
	logic [2:0]   y;
	logic [5:0]   c6;
	logic [3:0]   c4;
	logic         rd_mid;
	logic         rd_data;
	logic         k_hit;
	logic [9:0]   k_sym;
	logic [9:0]   sym;
	logic         rd_next;

	assign adv         = !valid_s2 || symbols.ready;
	assign bytes.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			beat_s1 <= bytes.payload;
		end
	end

	assign x = beat_s1.data_byte[4:0];
	assign y = beat_s1.data_byte[7:5];

	always_comb begin
		c6      = rd_q ? SIX_POS[x] : SIX_NEG[x];
		rd_mid  = rd_follow(rd_q, ones10({4'd0, c6}), 4'd3);
		c4      = rd_mid ? FOUR_POS[y] : FOUR_NEG[y];
		if (y == Y_P7) begin
			if (!rd_mid && (x == 5'd17 || x == 5'd18 || x == 5'd20)) begin
				c4 = A7_NEG;
			end else if (rd_mid && (x == 5'd11 || x == 5'd13 || x == 5'd14)) begin
				c4 = A7_POS;
			end
		end
		rd_data = rd_follow(rd_mid, ones10({6'd0, c4}), 4'd2);
	end

	always_comb begin
		k_hit = 1'b0;
		k_sym = ERR_SYMBOL;
		for (int i = 0; i < NUM_K; i++) begin
			if (beat_s1.data_byte == K_BYTE[i]) begin
				k_hit = 1'b1;
				k_sym = rd_q ? K_POS[i] : K_NEG[i];
			end
		end
	end

	always_comb begin
		if (beat_s1.cmd == CMD_DATA) begin
			sym     = {c4, c6};
			rd_next = rd_data;
		end else if (k_hit) begin
			sym     = k_sym;
			rd_next = rd_follow(rd_q, ones10(k_sym), 4'd5);
		end else begin
			sym     = ERR_SYMBOL;
			rd_next = rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rd_q     <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				rd_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			beat_s2.symbol          <= sym;
			beat_s2.unknown_control <= (beat_s1.cmd == CMD_CTRL) && !k_hit;
		end
	end

	assign symbols.valid   = valid_s2;
	assign symbols.payload = beat_s2;

`ifndef SYNTHESIS
	a_err_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && beat_s2.unknown_control |-> beat_s2.symbol == ERR_SYMBOL)
		else $error("unknown control beat without error symbol");

	a_symbol_weight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !beat_s2.unknown_control |->
		(ones10(beat_s2.symbol) == 4'd4 || ones10(beat_s2.symbol) == 4'd5 ||
		 ones10(beat_s2.symbol) == 4'd6))
		else $error("encoded symbol out of weight range");

	a_rd_hold_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && (beat_s1.cmd == CMD_CTRL) && !k_hit |=> rd_q == $past(rd_q))
		else $error("disparity moved on unknown control");

	a_rd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && valid_s1) |=> $stable(rd_q))
		else $error("disparity moved without a beat");
`endif

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for encode_8b10b_symbol_top: byte beats in, 10-bit symbols out, checked
// against a disparity-tracking 8b10b encoder kept in the bench itself.
// Depends on enc8b10b_pkg, enc8b10b_stream_if and the encoder RTL.
`timescale 1ns / 1ps

module tb;
	import enc8b10b_pkg::*;

	localparam logic [9:0] BAD_K_SYMBOL = 10'h3FF;
	localparam logic [3:0] ALT7_NEG     = 4'hE;
	localparam logic [3:0] ALT7_POS     = 4'h1;
	localparam logic [2:0] Y_SEVEN      = 3'd7;
	localparam int         HOLD_CYCLES  = 400;

	localparam logic [5:0] ABCDEI_NEG [32] = '{
		6'h39, 6'h2E, 6'h2D, 6'h23, 6'h2B, 6'h25, 6'h26, 6'h07,
		6'h27, 6'h29, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h3A,
		6'h36, 6'h31, 6'h32, 6'h13, 6'h34, 6'h15, 6'h16, 6'h17,
		6'h33, 6'h19, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h35
	};
	localparam logic [5:0] ABCDEI_POS [32] = '{
		6'h06, 6'h11, 6'h12, 6'h23, 6'h14, 6'h25, 6'h26, 6'h38,
		6'h18, 6'h29, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h05,
		6'h09, 6'h31, 6'h32, 6'h13, 6'h34, 6'h15, 6'h16, 6'h28,
		6'h0C, 6'h19, 6'h1A, 6'h24, 6'h1C, 6'h22, 6'h21, 6'h0A
	};
	localparam logic [3:0] FGHJ_NEG [8] = '{
		4'hD, 4'h9, 4'hA, 4'h3, 4'hB, 4'h5, 4'h6, 4'h7
	};
	localparam logic [3:0] FGHJ_POS [8] = '{
		4'h2, 4'h9, 4'hA, 4'hC, 4'h4, 4'h5, 4'h6, 4'h8
	};
	// K28.5, K28.1, K28.3, K27.7, K29.7, K23.7
	localparam logic [7:0] KCHAR_BYTE [6] = '{
		8'hBC, 8'h3C, 8'h7C, 8'hFB, 8'hFD, 8'hF7
	};
	localparam logic [9:0] KCHAR_NEG [6] = '{
		10'h17C, 10'h27C, 10'h33C, 10'h05B, 10'h05D, 10'h057
	};
	localparam logic [9:0] KCHAR_POS [6] = '{
		10'h283, 10'h183, 10'h0C3, 10'h3A4, 10'h3A2, 10'h3A8
	};
	localparam logic [4:0] ALT7_X [6] = '{5'd11, 5'd13, 5'd14, 5'd17, 5'd18, 5'd20};

	logic clk;
	logic arst_n;

	enc8b10b_stream_if #(.payload_t(byte_beat_t))   byte_ch();
	enc8b10b_stream_if #(.payload_t(symbol_beat_t)) symbol_ch();

	encode_8b10b_symbol_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.symbols (symbol_ch)
	);

	byte_beat_t   bytes_to_send[$];
	symbol_beat_t symbols_due[$];
	logic         line_rd;
	int           send_idle_pct;
	int           recv_stall_pct;
	logic         recv_hold_req;
	int           recv_hold_left;
	int           mismatches;

	function automatic logic next_rd(input logic rd, input int ones, input int half);
		if (ones > half) begin
			return 1'b1;
		end else if (ones < half) begin
			return 1'b0;
		end
		return rd;
	endfunction

	function automatic symbol_beat_t encode_byte(input byte_beat_t b, input logic rd_in,
			output logic rd_out);
		symbol_beat_t res;
		logic [4:0]   x;
		logic [2:0]   y;
		logic [5:0]   c6;
		logic [3:0]   c4;
		logic         rd;
		rd = rd_in;
		x = b.data_byte[4:0];
		y = b.data_byte[7:5];
		res.symbol = BAD_K_SYMBOL;
		res.unknown_control = 1'b0;
		if (b.cmd == CMD_DATA) begin
			c6 = rd ? ABCDEI_POS[x] : ABCDEI_NEG[x];
			rd = next_rd(rd, $countones(c6), 3);
			c4 = rd ? FGHJ_POS[y] : FGHJ_NEG[y];
			if (y == Y_SEVEN) begin
				if (!rd && (x == 5'd17 || x == 5'd18 || x == 5'd20)) begin
					c4 = ALT7_NEG;
				end else if (rd && (x == 5'd11 || x == 5'd13 || x == 5'd14)) begin
					c4 = ALT7_POS;
				end
			end
			rd = next_rd(rd, $countones(c4), 2);
			res.symbol = {c4, c6};
		end else begin
			res.unknown_control = 1'b1;
			for (int k = 0; k < 6; k++) begin
				if (res.unknown_control && KCHAR_BYTE[k] == b.data_byte) begin
					res.symbol = rd ? KCHAR_POS[k] : KCHAR_NEG[k];
					res.unknown_control = 1'b0;
				end
			end
			if (!res.unknown_control) begin
				rd = next_rd(rd, $countones(res.symbol), 5);
			end
		end
		rd_out = rd;
		return res;
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid   <= 1'b0;
			byte_ch.payload <= '0;
			line_rd         <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				logic nrd;
				symbols_due.push_back(encode_byte(byte_ch.payload, line_rd, nrd));
				line_rd <= nrd;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_ch.valid   <= 1'b1;
					byte_ch.payload <= bytes_to_send.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_hold_left <= 0;
		end else if (recv_hold_left != 0) begin
			recv_hold_left <= recv_hold_left - 1;
		end else if (recv_hold_req) begin
			recv_hold_left <= HOLD_CYCLES;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_ch.ready <= 1'b0;
		end else begin
			if (symbol_ch.valid && symbol_ch.ready) begin
				if (symbols_due.size() == 0) begin
					$display("%0t: unexpected beat symbol=%h unknown_control=%b", $time,
						symbol_ch.payload.symbol, symbol_ch.payload.unknown_control);
					mismatches++;
				end else begin
					symbol_beat_t want;
					want = symbols_due.pop_front();
					if (symbol_ch.payload.symbol !== want.symbol) begin
						$display("%0t: symbol expected %h actual %h", $time,
							want.symbol, symbol_ch.payload.symbol);
						mismatches++;
					end
					if (symbol_ch.payload.unknown_control !== want.unknown_control) begin
						$display("%0t: unknown_control expected %b actual %b", $time,
							want.unknown_control, symbol_ch.payload.unknown_control);
						mismatches++;
					end
				end
			end
			symbol_ch.ready <= (recv_hold_left == 0) && !recv_hold_req &&
				($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_byte(input logic cmd, input logic [7:0] b);
		byte_beat_t it;
		it.cmd = cmd;
		it.data_byte = b;
		bytes_to_send.push_back(it);
	endtask

	task automatic push_random_byte();
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			push_byte(CMD_DATA, 8'($urandom_range(255)));
		end else if (r < 70) begin
			push_byte(CMD_DATA, {Y_SEVEN, ALT7_X[$urandom_range(5)]});
		end else if (r < 85) begin
			push_byte(CMD_CTRL, KCHAR_BYTE[$urandom_range(5)]);
		end else begin
			push_byte(CMD_CTRL, 8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drained();
		while (bytes_to_send.size() != 0 || byte_ch.valid || symbols_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_random(input int n, input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < n; i++) begin
			push_random_byte();
		end
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold_req  = 1'b0;
		mismatches     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// D.x.7 bytes eligible for the alternate A7 code, all K codes, bad K bytes
		push_byte(CMD_DATA, 8'h00);
		push_byte(CMD_DATA, 8'hFF);
		push_byte(CMD_DATA, 8'hF1);
		push_byte(CMD_CTRL, 8'hBC);
		push_byte(CMD_DATA, 8'hEB);
		push_byte(CMD_DATA, 8'hF2);
		push_byte(CMD_DATA, 8'hED);
		push_byte(CMD_DATA, 8'hF4);
		push_byte(CMD_DATA, 8'hEE);
		push_byte(CMD_CTRL, 8'h3C);
		push_byte(CMD_CTRL, 8'h7C);
		push_byte(CMD_CTRL, 8'hFB);
		push_byte(CMD_CTRL, 8'hFD);
		push_byte(CMD_CTRL, 8'hF7);
		push_byte(CMD_CTRL, 8'h00);
		push_byte(CMD_CTRL, 8'hFF);
		push_byte(CMD_CTRL, 8'hBC);
		push_byte(CMD_CTRL, 8'hBD);
		push_byte(CMD_DATA, 8'h1C);
		push_byte(CMD_DATA, 8'hFC);
		push_byte(CMD_DATA, 8'hA5);
		push_byte(CMD_DATA, 8'h4A);
		push_byte(CMD_DATA, 8'hC6);
		push_byte(CMD_DATA, 8'h27);
		wait_drained();

		run_random(360, 0, 0);
		run_random(280, 81, 0);
		run_random(280, 0, 81);
		run_random(280, 32, 32);

		recv_hold_req = 1'b1;
		while (recv_hold_left == 0) @(negedge clk);
		recv_hold_req = 1'b0;
		run_random(60, 0, 0);

		run_random(240, 10, 10);

		repeat (20) @(negedge clk);
		if (mismatches == 0 && symbols_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
rtl/core/enc8b10b_pkg.sv
rtl/core/enc8b10b_stream_if.sv
rtl/core/encode_8b10b_symbol_top.sv
test/tb.sv
